/* sv/three_axis_pidf_rate_controller_macros.svh */
// Assertion helpers for the controller top level.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef THREE_AXIS_PIDF_RATE_CONTROLLER_MACROS_SVH
`define THREE_AXIS_PIDF_RATE_CONTROLLER_MACROS_SVH

// cond must hold at every clock edge outside reset
`define PRC_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/prc_pkg.sv */
package prc_pkg;

    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;
    localparam int GAIN_W   = 16;
    localparam int RATE_W   = 16;
    localparam int OPA_W    = 34;
    localparam int OPB_W    = 18;
    localparam int PROD_W   = OPA_W + OPB_W;
    localparam int ACC_W    = 40;
    localparam int DRIVE_W  = 32;
    localparam int FRAC_DT  = 16;
    localparam int ROUND_DT = 32768;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    // Kf = 1.0 in Q4.12, other gains zero
    localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 64'h1000_0000_0000_0000;

    localparam logic signed [DRIVE_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DRIVE_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROLL  = 2'd0,
        REG_PITCH = 2'd1,
        REG_YAW   = 2'd2
    } reg_index_t;

    // multiplier operations, in issue order for one axis
    typedef enum logic [2:0] {
        OP_D1 = 3'd0,   // Kd * (previous rate - rate)
        OP_D2 = 3'd1,   // previous product * dt
        OP_F1 = 3'd2,   // Kf * (target - previous target)
        OP_F2 = 3'd3,   // previous product * dt
        OP_P  = 3'd4,   // Kp * error
        OP_I  = 3'd5    // Ki * error
    } op_t;

    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [AXIS_W-1:0] axis;
    } mul_ctrl_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] roll_target;
        logic signed [RATE_W-1:0] pitch_target;
        logic signed [RATE_W-1:0] yaw_target;
        logic signed [RATE_W-1:0] roll_rate;
        logic signed [RATE_W-1:0] pitch_rate;
        logic signed [RATE_W-1:0] yaw_rate;
        logic [15:0]              throttle_in;
        logic [15:0]              tick_length;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] roll_drive;
        logic signed [DRIVE_W-1:0] pitch_drive;
        logic signed [DRIVE_W-1:0] yaw_drive;
        logic [15:0]               throttle_out;
    } out_item_t;

    function automatic logic signed [DRIVE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DRIVE_W-1:0] r;
        if (v > ACC_W'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (v < ACC_W'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = DRIVE_W'(v);
        end
        return r;
    endfunction

    // Q.28 -> Q.12, round half up
    function automatic logic signed [ACC_W-1:0] round_dt(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W:0] s;
        logic signed [PROD_W:0] q;
        s = (PROD_W+1)'(v) + (PROD_W+1)'(ROUND_DT);
        q = s >>> FRAC_DT;
        return ACC_W'(q);
    endfunction

endpackage

/* sv/prc_stream_if.sv */
interface prc_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/prc_cfg_if.sv */
interface prc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [prc_pkg::CFG_IDX_W-1:0]    index;
    logic [prc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/prc_mul.sv */
module prc_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  prc_pkg::mul_ctrl_t                 ctrl,
    input  logic signed [prc_pkg::OPA_W-1:0]   a,
    input  logic signed [prc_pkg::OPB_W-1:0]   b,
    output prc_pkg::mul_ctrl_t                 tag,
    output logic signed [prc_pkg::PROD_W-1:0]  prod
);
    import prc_pkg::*;

    mul_ctrl_t                 tag_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            prod_reg <= a * b;
        end
    end

    assign tag  = tag_reg;
    assign prod = prod_reg;

endmodule

/* sv/prc_seq.sv */
module prc_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output prc_pkg::mul_ctrl_t issue,
    output logic               idle
);
    import prc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    op_t               op_reg, op_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic              drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_D1;
            axis_reg  <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            axis_reg  <= axis_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        axis_next  = axis_reg;
        drain_next = drain_reg;
        issue      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    op_next    = OP_D1;
                    axis_next  = '0;
                end
            end
            S_RUN:
            begin
                issue.valid = 1'b1;
                issue.op    = op_reg;
                issue.axis  = axis_reg;
                unique case (op_reg)
                    OP_D1: op_next = OP_D2;
                    OP_D2: op_next = OP_F1;
                    OP_F1: op_next = OP_F2;
                    OP_F2: op_next = OP_P;
                    OP_P:  op_next = OP_I;
                    OP_I:
                    begin
                        op_next = OP_D1;
                        if (axis_reg == AXIS_W'(AXES - 1))
                        begin
                            state_next = S_DRAIN;
                            drain_next = 1'b0;
                        end
                        else
                        begin
                            axis_next = axis_reg + 1'b1;
                        end
                    end
                    default: op_next = OP_D1;
                endcase
            end
            S_DRAIN:
            begin
                // wait out the last integrator update, then the last sum
                if (drain_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    drain_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign idle = (state_reg == S_IDLE);

endmodule

/* sv/prc_accum.sv */
module prc_accum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  prc_pkg::mul_ctrl_t                 tag,
    input  logic signed [prc_pkg::PROD_W-1:0]  prod,
    output logic signed [prc_pkg::DRIVE_W-1:0] drive [prc_pkg::AXES],
    output logic                               fin_last
);
    import prc_pkg::*;

    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [DRIVE_W-1:0] integ_reg [AXES];
    logic signed [DRIVE_W-1:0] integ_next;
    logic signed [DRIVE_W-1:0] integ_new_reg;
    logic signed [DRIVE_W-1:0] drive_reg [AXES];
    logic                      fin_valid_reg;
    logic [AXIS_W-1:0]         fin_axis_reg;
    logic signed [ACC_W-1:0]   integ_sum;
    logic signed [ACC_W-1:0]   drive_sum;
    logic                      integ_we;

    always_comb
    begin
        acc_next = acc_reg;
        if (tag.valid)
        begin
            case (tag.op) inside
                OP_D2:        acc_next = round_dt(prod);
                OP_F2:        acc_next = acc_reg + round_dt(prod);
                OP_P:         acc_next = acc_reg + ACC_W'(prod);
                OP_D1, OP_F1, OP_I: acc_next = acc_reg;
                default:      acc_next = acc_reg;
            endcase
        end
    end

    assign integ_we   = tag.valid && (tag.op == OP_I);
    assign integ_sum  = ACC_W'(integ_reg[tag.axis]) + ACC_W'(prod);
    assign integ_next = sat32(integ_sum);
    assign drive_sum  = acc_reg + ACC_W'(integ_new_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                integ_reg[i] <= '0;
            end
            fin_valid_reg <= 1'b0;
            fin_axis_reg  <= '0;
        end
        else
        begin
            if (integ_we)
            begin
                integ_reg[tag.axis] <= integ_next;
            end
            fin_valid_reg <= integ_we;
            fin_axis_reg  <= tag.axis;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (integ_we)
        begin
            integ_new_reg <= integ_next;
        end
        if (fin_valid_reg)
        begin
            drive_reg[fin_axis_reg] <= sat32(drive_sum);
        end
    end

    assign drive    = drive_reg;
    assign fin_last = fin_valid_reg && (fin_axis_reg == AXIS_W'(AXES - 1));

endmodule

/* sv/three_axis_pidf_rate_controller.sv */
// Channel  | Dir | Handshake           | Item
// ---------+-----+---------------------+-----------------------------------------
// tick     | in  | tick.valid/ready    | targets, gyro rates, throttle, dt
// result   | out | result.valid/ready  | roll/pitch/yaw drive, throttle copy
// cfg      | in  | cfg.valid/ready     | gain register index and 64-bit value
//
// Each accepted tick runs 18 multiplies (six per axis) on one shared 34x18
// multiplier; the last axis is then finished and the result loaded into the
// output register, where result valid and tick ready rise together.
// rst_n (async, low) clears gains to Kf = 1.0, integrators and history.
// A held result lets the next item run; ready then stays low until the
// output register frees up. cfg is always ready.
`include "three_axis_pidf_rate_controller_macros.svh"

module three_axis_pidf_rate_controller (
    input  logic          clk,
    input  logic          rst_n,
    prc_stream_if.sink    tick,
    prc_stream_if.source  result,
    prc_cfg_if.sink       cfg
);
    import prc_pkg::*;

    // configuration: one 64-bit gain word per axis
    logic [CFG_DATA_W-1:0]     gains_reg [AXES];

    // item held for the whole run
    logic signed [RATE_W-1:0]  target_reg [AXES];
    logic signed [RATE_W-1:0]  rate_reg [AXES];
    logic [15:0]               thr_reg;
    logic [15:0]               dt_reg;

    // history from the previous tick
    logic signed [RATE_W-1:0]  prev_rate_reg [AXES];
    logic signed [RATE_W-1:0]  prev_target_reg [AXES];

    // output side
    logic                      res_pending_reg;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;
    logic                      load_out;

    logic                      accept;
    logic                      seq_idle;
    mul_ctrl_t                 issue;
    mul_ctrl_t                 mul_tag;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [OPA_W-1:0]   op_a;
    logic signed [OPB_W-1:0]   op_b;
    logic signed [DRIVE_W-1:0] drive [AXES];
    logic                      fin_last;

    // operand fields for the axis being issued
    logic [CFG_DATA_W-1:0]     g;
    logic signed [GAIN_W-1:0]  kp, ki, kd, kf;
    logic signed [OPB_W-1:0]   err_b, pv_b, sp_b, dt_b;

    assign accept     = tick.valid && tick.ready;
    assign tick.ready = seq_idle && !res_pending_reg;
    assign cfg.ready  = 1'b1;

    // ---------------------------------------------------------------
    // gain registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                gains_reg[i] <= GAIN_RESET;
            end
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ROLL:  gains_reg[0] <= cfg.data;
                REG_PITCH: gains_reg[1] <= cfg.data;
                REG_YAW:   gains_reg[2] <= cfg.data;
                default:   ;    // writes past the last register are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // item capture
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg[0] <= tick.data.roll_target;
            target_reg[1] <= tick.data.pitch_target;
            target_reg[2] <= tick.data.yaw_target;
            rate_reg[0]   <= tick.data.roll_rate;
            rate_reg[1]   <= tick.data.pitch_rate;
            rate_reg[2]   <= tick.data.yaw_rate;
            thr_reg       <= tick.data.throttle_in;
            dt_reg        <= tick.data.tick_length;
        end
    end

    // history is committed when the last axis sum completes, so every
    // multiply of this tick has already seen the old values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                prev_rate_reg[i]   <= '0;
                prev_target_reg[i] <= '0;
            end
        end
        else if (fin_last)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                prev_rate_reg[i]   <= rate_reg[i];
                prev_target_reg[i] <= target_reg[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // sequencer and shared multiplier
    // ---------------------------------------------------------------
    prc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .issue (issue),
        .idle  (seq_idle)
    );

    assign g     = gains_reg[issue.axis];
    assign kp    = g[GAIN_W-1:0];
    assign ki    = g[2*GAIN_W-1:GAIN_W];
    assign kd    = g[3*GAIN_W-1:2*GAIN_W];
    assign kf    = g[4*GAIN_W-1:3*GAIN_W];
    assign err_b = OPB_W'(target_reg[issue.axis]) - OPB_W'(rate_reg[issue.axis]);
    assign pv_b  = OPB_W'(prev_rate_reg[issue.axis]) - OPB_W'(rate_reg[issue.axis]);
    assign sp_b  = OPB_W'(target_reg[issue.axis]) - OPB_W'(prev_target_reg[issue.axis]);
    assign dt_b  = signed'(OPB_W'(dt_reg));

    // D2 and F2 chain on the product of the step right before them
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (issue.op) inside
            OP_D1:
            begin
                op_a = OPA_W'(kd);
                op_b = pv_b;
            end
            OP_F1:
            begin
                op_a = OPA_W'(kf);
                op_b = sp_b;
            end
            OP_D2, OP_F2:
            begin
                op_a = OPA_W'(mul_prod);
                op_b = dt_b;
            end
            OP_P:
            begin
                op_a = OPA_W'(kp);
                op_b = err_b;
            end
            OP_I:
            begin
                op_a = OPA_W'(ki);
                op_b = err_b;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    prc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (issue),
        .a     (op_a),
        .b     (op_b),
        .tag   (mul_tag),
        .prod  (mul_prod)
    );

    // accumulates D, F, P into one sum, updates the integrator, saturates
    prc_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag      (mul_tag),
        .prod     (mul_prod),
        .drive    (drive),
        .fin_last (fin_last)
    );

    // ---------------------------------------------------------------
    // output register: a finished result waits here; the next one waits in the datapath
    // ---------------------------------------------------------------
    assign load_out = res_pending_reg && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fin_last)
            begin
                res_pending_reg <= 1'b1;
            end
            else if (load_out)
            begin
                res_pending_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg.roll_drive   <= drive[0];
            out_data_reg.pitch_drive  <= drive[1];
            out_data_reg.yaw_drive    <= drive[2];
            out_data_reg.throttle_out <= thr_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `PRC_ASSERT_NEXT(a_busy_after_accept, accept, !tick.ready, "item accepted while busy")
    `PRC_ASSERT_NOW(a_no_issue_pending, !(issue.valid && res_pending_reg), "issue with result held")
    `PRC_ASSERT_NEXT(a_fin_sets_pending, fin_last, res_pending_reg, "last sum not held")
    `PRC_ASSERT_NOW(a_fin_after_drain, !(fin_last && mul_tag.valid), "last sum overlaps a product")

endmodule

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prc_pkg::*;

    // index 3 is outside the register map; the block must ignore the write
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    localparam logic [CFG_DATA_W-1:0] GAINS_MAX = 64'h7FFF_7FFF_7FFF_7FFF;
    localparam logic [CFG_DATA_W-1:0] GAINS_MIN = 64'h8000_8000_8000_8000;

    localparam int RAND_PHASE_ITEMS = 345;
    localparam int RETUNE_EVERY     = 115;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int TAIL_CYCLES      = 40;

    logic clk;
    logic rst_n;

    prc_stream_if #(.item_t(in_item_t))  tick_if ();
    prc_stream_if #(.item_t(out_item_t)) res_if ();
    prc_cfg_if                           cfg_if ();

    three_axis_pidf_rate_controller uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // one row of the directed part: either a gain write or a tick item,
    // with the drive values typed in where they are obvious
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        in_item_t              stim;
        bit                    typed;
        out_item_t             want;
    } dir_row_t;

    // shadow of the controller: gains, integrators and history per axis
    logic [CFG_DATA_W-1:0]     gain_reg     [AXES];
    logic signed [DRIVE_W-1:0] integ_st     [AXES];
    logic signed [RATE_W-1:0]  prev_rate_st [AXES];
    logic signed [RATE_W-1:0]  prev_tgt_st  [AXES];

    out_item_t drive_q [$];     // expected drive items, oldest first
    int        mismatch_cnt;
    int        src_pct;         // chance in 100 that the sender idles a cycle
    int        sink_pct;        // chance in 100 that the receiver stalls a cycle
    bit        hold_req;        // asks the receiver for one long stall

    dir_row_t  dir_rows [$];
    in_item_t  last_tick;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // the limit allows more than ten times the worst case for ~1100 items plus the
    // long stall
    initial
    begin
        #10ms;
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic signed [DRIVE_W-1:0] clip_word(input longint v);
        logic signed [DRIVE_W-1:0] r;
        if (v > longint'(SAT_MAX))
        begin
            r = SAT_MAX;
        end
        else if (v < longint'(SAT_MIN))
        begin
            r = SAT_MIN;
        end
        else
        begin
            r = DRIVE_W'(v);
        end
        return r;
    endfunction

    // one control tick: returns the drive item and moves the shadow state on
    function automatic out_item_t advance_controller(input in_item_t it);
        out_item_t                 o;
        logic signed [RATE_W-1:0]  tg [AXES];
        logic signed [RATE_W-1:0]  rt [AXES];
        logic signed [DRIVE_W-1:0] drv [AXES];
        longint kp, ki, kd, kf, err, pv_err, sp_delta, dt, p_term, d_term, f_term;
        tg[0] = it.roll_target;
        tg[1] = it.pitch_target;
        tg[2] = it.yaw_target;
        rt[0] = it.roll_rate;
        rt[1] = it.pitch_rate;
        rt[2] = it.yaw_rate;
        dt = longint'(it.tick_length);
        for (int a = 0; a < AXES; a++)
        begin
            kp = longint'($signed(gain_reg[a][15:0]));
            ki = longint'($signed(gain_reg[a][31:16]));
            kd = longint'($signed(gain_reg[a][47:32]));
            kf = longint'($signed(gain_reg[a][63:48]));
            err      = longint'(tg[a]) - longint'(rt[a]);
            pv_err   = longint'(prev_rate_st[a]) - longint'(rt[a]);
            sp_delta = longint'(tg[a]) - longint'(prev_tgt_st[a]);
            p_term = kp * err;
            // Q.28 down to Q.12, half rounds toward +inf
            d_term = (kd * pv_err * dt + 64'sd32768) >>> FRAC_DT;
            f_term = (kf * sp_delta * dt + 64'sd32768) >>> FRAC_DT;
            integ_st[a] = clip_word(longint'(integ_st[a]) + ki * err);
            drv[a] = clip_word(p_term + longint'(integ_st[a]) + d_term + f_term);
            prev_rate_st[a] = rt[a];
            prev_tgt_st[a]  = tg[a];
        end
        o.roll_drive   = drv[0];
        o.pitch_drive  = drv[1];
        o.yaw_drive    = drv[2];
        o.throttle_out = it.throttle_in;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic dir_row_t tick_row(input in_item_t s, input bit typed,
                                          input out_item_t w);
        dir_row_t r;
        r.is_cfg = 1'b0;
        r.idx    = REG_ROLL;
        r.val    = '0;
        r.stim   = s;
        r.typed  = typed;
        r.want   = w;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        r.stim   = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    // rate/target word: extremes, values near zero, or anything
    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        case ($urandom_range(7))
            0: w = 16'h7FFF;
            1: w = 16'h8000;
            2: w = 16'($urandom_range(0, 127)) - 16'd64;
            default: w = 16'($urandom);
        endcase
        return w;
    endfunction

    function automatic in_item_t random_tick(input in_item_t prev);
        in_item_t s;
        s.roll_target  = pick_word();
        s.pitch_target = pick_word();
        s.yaw_target   = pick_word();
        s.roll_rate    = pick_word();
        s.pitch_rate   = pick_word();
        s.yaw_rate     = pick_word();
        s.throttle_in  = 16'($urandom);
        // held setpoints now and then, so the F term drops out
        if ($urandom_range(7) == 0)
        begin
            s.roll_target  = prev.roll_target;
            s.pitch_target = prev.pitch_target;
            s.yaw_target   = prev.yaw_target;
        end
        case ($urandom_range(5))
            0: s.tick_length = 16'h0000;
            1: s.tick_length = 16'hFFFF;
            2: s.tick_length = 16'($urandom_range(0, 255));
            default: s.tick_length = 16'($urandom);
        endcase
        return s;
    endfunction

    // a gain set: wild, around +-1.0, the corners, or tiny
    function automatic logic [CFG_DATA_W-1:0] pick_gains();
        logic [CFG_DATA_W-1:0] g;
        int                    k;
        k = $urandom_range(3);
        for (int i = 0; i < 4; i++)
        begin
            case (k)
                0: g[16*i +: 16] = 16'($urandom);
                1: g[16*i +: 16] = 16'($urandom_range(0, 8191)) - 16'd4096;
                2:
                begin
                    case ($urandom_range(3))
                        0: g[16*i +: 16] = 16'h7FFF;
                        1: g[16*i +: 16] = 16'h8000;
                        2: g[16*i +: 16] = 16'h0000;
                        default: g[16*i +: 16] = 16'h1000;
                    endcase
                end
                default: g[16*i +: 16] = 16'($urandom_range(0, 63)) - 16'd32;
            endcase
        end
        return g;
    endfunction

    // Offer one tick item and wait for it to be taken. Valid is left high at
    // the accept edge; the next call either lowers it or reloads it there.
    task automatic push_tick(input in_item_t s, input bit typed, input out_item_t w);
        out_item_t pred;
        cfg_if.valid <= 1'b0;
        while ($urandom_range(99) < src_pct)
        begin
            tick_if.valid <= 1'b0;
            @(posedge clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.data  <= s;
        do
            @(posedge clk);
        while (tick_if.ready !== 1'b1);
        pred = advance_controller(s);
        drive_q.push_back(typed ? w : pred);
        last_tick = s;
    endtask

    // stop offering and let every expected drive item come back
    task automatic drain_drives();
        int n;
        n = 0;
        tick_if.valid <= 1'b0;
        while (drive_q.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // gain write; only issued with nothing in flight
    task automatic write_gains(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        if (idx != REG_NONE)
        begin
            gain_reg[idx] = val;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long hold on request, and the checker
    // ------------------------------------------------------------------
    initial
    begin
        int        hold_left;
        out_item_t got;
        out_item_t want;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            begin
                got = res_if.data;
                if (drive_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("unexpected drive item: roll %h pitch %h yaw %h thr %h",
                                 got.roll_drive, got.pitch_drive, got.yaw_drive,
                                 got.throttle_out);
                    end
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got.roll_drive !== want.roll_drive ||
                        got.pitch_drive !== want.pitch_drive ||
                        got.yaw_drive !== want.yaw_drive ||
                        got.throttle_out !== want.throttle_out)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $display("drive mismatch: exp roll %h pitch %h yaw %h thr %h",
                                     want.roll_drive, want.pitch_drive, want.yaw_drive,
                                     want.throttle_out);
                            $display("                got roll %h pitch %h yaw %h thr %h",
                                     got.roll_drive, got.pitch_drive, got.yaw_drive,
                                     got.throttle_out);
                        end
                    end
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= ($urandom_range(99) >= sink_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        tick_if.valid = 1'b0;
        tick_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = REG_ROLL;
        cfg_if.data   = '0;
        mismatch_cnt  = 0;
        hold_req      = 1'b0;
        last_tick     = '0;
        for (int a = 0; a < AXES; a++)
        begin
            gain_reg[a]     = GAIN_RESET;
            integ_st[a]     = '0;
            prev_rate_st[a] = '0;
            prev_tgt_st[a]  = '0;
        end

        // directed part runs with the first idle mix
        src_pct  = 26;
        sink_pct = 69;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset only Kf = 1.0; zero setpoints and a zero tick give nothing
        dir_rows.push_back(tick_row('{16'sh0000, 16'sh0000, 16'sh0000,
                                      16'sh7FFF, 16'sh8000, 16'sh1234,
                                      16'hFFFF, 16'h0000}, 1'b1,
                                    '{32'sh0, 32'sh0, 32'sh0, 16'hFFFF}));
        // zero tick length kills D and F even for extreme setpoint jumps
        dir_rows.push_back(tick_row('{16'sh7FFF, 16'sh8000, 16'sh0001,
                                      16'sh0000, 16'sh0000, 16'sh0000,
                                      16'h0000, 16'h0000}, 1'b1,
                                    '{32'sh0, 32'sh0, 32'sh0, 16'h0000}));
        // full tick with the setpoints swung back to zero
        dir_rows.push_back(tick_row('{16'sh0000, 16'sh0000, 16'sh0000,
                                      16'sh0000, 16'sh0000, 16'sh0000,
                                      16'h5A5A, 16'hFFFF}, 1'b0, '0));
        // rounding of a half step, positive and negative
        dir_rows.push_back(tick_row('{16'sh0001, 16'shFFFF, 16'sh0001,
                                      16'sh0000, 16'sh0000, 16'sh0000,
                                      16'h0001, 16'h0008}, 1'b0, '0));
        dir_rows.push_back(cfg_row(REG_ROLL,  GAINS_MAX));
        dir_rows.push_back(cfg_row(REG_PITCH, GAINS_MAX));
        dir_rows.push_back(cfg_row(REG_YAW,   GAINS_MAX));
        // largest positive error with largest gains: sum overflow
        dir_rows.push_back(tick_row('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                      16'sh8000, 16'sh8000, 16'sh8000,
                                      16'h8001, 16'hFFFF}, 1'b1,
                                    '{SAT_MAX, SAT_MAX, SAT_MAX, 16'h8001}));
        // integrator runs into the positive limit
        dir_rows.push_back(tick_row('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                      16'sh8000, 16'sh8000, 16'sh8000,
                                      16'h0000, 16'h0000}, 1'b1,
                                    '{SAT_MAX, SAT_MAX, SAT_MAX, 16'h0000}));
        // full swing the other way: sum underflow
        dir_rows.push_back(tick_row('{16'sh8000, 16'sh8000, 16'sh8000,
                                      16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                      16'hFFFF, 16'hFFFF}, 1'b1,
                                    '{SAT_MIN, SAT_MIN, SAT_MIN, 16'hFFFF}));
        dir_rows.push_back(tick_row('{16'sh8000, 16'sh8000, 16'sh8000,
                                      16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                      16'h1111, 16'h0000}, 1'b1,
                                    '{SAT_MIN, SAT_MIN, SAT_MIN, 16'h1111}));
        // integrator reaches the negative limit
        dir_rows.push_back(tick_row('{16'sh8000, 16'sh8000, 16'sh8000,
                                      16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                      16'h2222, 16'h0000}, 1'b1,
                                    '{SAT_MIN, SAT_MIN, SAT_MIN, 16'h2222}));
        dir_rows.push_back(cfg_row(REG_ROLL,  GAINS_MIN));
        dir_rows.push_back(cfg_row(REG_PITCH, GAINS_MIN));
        dir_rows.push_back(cfg_row(REG_YAW,   GAINS_MIN));
        // most negative gains: the integrator stays pinned low, then a flipped error drives the sum high
        dir_rows.push_back(tick_row('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                      16'sh8000, 16'sh8000, 16'sh8000,
                                      16'h3333, 16'hFFFF}, 1'b1,
                                    '{SAT_MIN, SAT_MIN, SAT_MIN, 16'h3333}));
        dir_rows.push_back(tick_row('{16'sh8000, 16'sh8000, 16'sh8000,
                                      16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                      16'h4444, 16'hFFFF}, 1'b1,
                                    '{SAT_MAX, SAT_MAX, SAT_MAX, 16'h4444}));
        // one term per axis
        dir_rows.push_back(cfg_row(REG_ROLL,  64'h0000_0000_0000_1000));
        dir_rows.push_back(cfg_row(REG_PITCH, 64'h0000_0000_1000_0000));
        dir_rows.push_back(cfg_row(REG_YAW,   64'h0000_1000_0000_0000));
        dir_rows.push_back(tick_row('{16'sd100, 16'sd200, 16'sd300,
                                      16'sd40, 16'sd50, 16'sd60,
                                      16'h00FF, 16'h8000}, 1'b0, '0));
        // write outside the map, must leave the gains alone
        dir_rows.push_back(cfg_row(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF));
        dir_rows.push_back(tick_row('{16'sh1234, 16'shEDCB, 16'sh0F0F,
                                      16'shF0F0, 16'sh5555, 16'shAAAA,
                                      16'hFF00, 16'h0001}, 1'b0, '0));
        dir_rows.push_back(tick_row('{16'sh1235, 16'shEDCA, 16'sh0F10,
                                      16'shF0F0, 16'sh5555, 16'shAAAA,
                                      16'h00FF, 16'h0008}, 1'b0, '0));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                drain_drives();
                write_gains(dir_rows[i].idx, dir_rows[i].val);
            end
            else
            begin
                push_tick(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // random part: three idle mixes, gains retuned while idle
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_pct  = 26;
                    sink_pct = 69;
                end
                1:
                begin
                    src_pct  = 69;
                    sink_pct = 26;
                end
                default:
                begin
                    src_pct  = 0;
                    sink_pct = 0;
                end
            endcase
            for (int n = 0; n < RAND_PHASE_ITEMS; n++)
            begin
                if (n % RETUNE_EVERY == 0)
                begin
                    drain_drives();
                    write_gains(REG_ROLL,  pick_gains());
                    write_gains(REG_PITCH, pick_gains());
                    write_gains(REG_YAW,   pick_gains());
                    if ($urandom_range(3) == 0)
                    begin
                        write_gains(REG_NONE, {$urandom, $urandom});
                    end
                end
                // receiver holds off while the sender keeps offering
                if (ph == 2 && n == 60)
                begin
                    hold_req = 1'b1;
                end
                // sender waits for the pipeline to empty mid-phase
                if (ph == 1 && n == 200)
                begin
                    drain_drives();
                end
                push_tick(random_tick(last_tick), 1'b0, '0);
            end
        end

        drain_drives();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (drive_q.size() != 0)
        begin
            mismatch_cnt++;
        end

        if (mismatch_cnt == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/prc_pkg.sv
sv/prc_stream_if.sv
sv/prc_cfg_if.sv
sv/prc_mul.sv
sv/prc_seq.sv
sv/prc_accum.sv
sv/three_axis_pidf_rate_controller.sv
bench/tb.sv
